// ----- hw/rtl/ktw_pkg.sv -----
// Package: shared types, constants and codes of the keepalive timing wheel.
`default_nettype none
package ktw_pkg;
    localparam int WHEEL_SLOTS = 64;
    localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
    localparam int NUM_PEERS   = 32;
    localparam int PEER_W      = 5;
    localparam int TIME_W      = 32;
    localparam int KI_W        = 6;
    localparam int CUR_W       = 8;
    localparam int CNT_W       = SLOT_W + 1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_NEW   = 2'd1,
        ST_WHEEL = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_ENABLE   = 1'b1;

    localparam logic KIND_PING  = 1'b0;
    localparam logic KIND_DELAY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP,
        S_NEW,
        S_BKT,
        S_DISP,
        S_DLY
    } t_state;

    typedef struct packed {
        logic              ping;
        logic [SLOT_W-1:0] bucket;
    } t_disp;
endpackage
`default_nettype wire

// ----- hw/rtl/keepalive_timing_wheel_unit.sv -----
// Top level: keepalive timing wheel with peer table and tick sequencer.
// Usage:
//   Commands enter on i_start when o_busy is low: add peer, record transmit
//   time, remove peer or tick with the current time.
//   A tick first advances the wheel one bucket per cycle (up to 64 buckets),
//   then dispatches new peers and then peers of expired buckets, then scans
//   ahead one bucket per cycle (up to interval buckets, at least one) for the
//   next occupied bucket. Peers are dispatched one at a time, as there is a
//   single dispatch unit and a one-port transmit-time memory.
//   Results appear on o_valid for one cycle each: a ping per peer due, then
//   one delay result with o_last high. The receiver cannot stall.
//   Registers are written through i_cfg_we/i_cfg_addr/i_cfg_data; the user
//   must write them only while idle, as the block does not enforce it.
//   Reset clears all peers to free, the wheel base and cursor to zero,
//   the interval to 20 and enables ticks. Transmit times are unset until
//   recorded.
`default_nettype none
module keepalive_timing_wheel_unit
    import ktw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_command,
    input  wire logic [PEER_W-1:0] i_peer_id,
    input  wire logic [TIME_W-1:0] i_now_seconds,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [KI_W-1:0]   i_cfg_data,
    output logic                   o_valid,
    output logic                   o_kind,
    output logic [PEER_W-1:0]      o_peer_id_res,
    output logic [KI_W-1:0]        o_delay_seconds,
    output logic                   o_last
);
    t_state                r_state, n_state;
    logic [KI_W-1:0]       r_interval;
    logic                  r_enable;
    logic [TIME_W-1:0]     r_base;
    logic [CUR_W-1:0]      r_cursor;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_wbase;
    logic [CNT_W-1:0]      r_nexp;
    logic [CNT_W-1:0]      r_pos;
    logic [SLOT_W-1:0]     r_oldcur;
    logic [KI_W-1:0]       r_i;
    logic                  r_phase_bkt;
    logic [PEER_W-1:0]     r_pid;
    logic [TIME_W-1:0]     r_rdata;
    logic [NUM_PEERS-1:0]  r_coll;
    t_status               r_status [NUM_PEERS];
    logic [SLOT_W-1:0]     r_bucket [NUM_PEERS];
    logic [TIME_W-1:0]     mem_tx   [NUM_PEERS];

    logic                  r_ovalid;
    logic                  r_okind;
    logic [PEER_W-1:0]     r_opid;
    logic [KI_W-1:0]       r_odelay;
    logic                  r_olast;

    logic                  accept;
    logic [SLOT_W-1:0]     tgt;
    logic [NUM_PEERS-1:0]  mask;
    logic                  any;
    logic [PEER_W-1:0]     pick;
    t_disp                 dres;
    logic [KI_W:0]         inext;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign inext  = {1'b0, r_i} + 1'b1;

    ktw_dispatch u_disp (
        .i_last_tx  (r_rdata),
        .i_now      (r_now),
        .i_interval (r_interval),
        .i_cursor   (r_cursor[SLOT_W-1:0]),
        .o_res      (dres)
    );

    always_comb begin
        tgt = (r_state == S_DLY) ? (r_cursor[SLOT_W-1:0] + r_i[SLOT_W-1:0])
                                 : (r_oldcur + r_pos[SLOT_W-1:0]);
        for (int p = 0; p < NUM_PEERS; p++) begin
            case (r_state)
                S_NEW:   mask[p] = (r_status[p] == ST_NEW);
                S_BKT:   mask[p] = (r_status[p] == ST_WHEEL) && !r_coll[p] &&
                                   (r_bucket[p] == tgt);
                S_DLY:   mask[p] = (r_status[p] == ST_WHEEL) && (r_bucket[p] == tgt);
                default: mask[p] = 1'b0;
            endcase
        end
        any  = |mask;
        pick = '0;
        for (int p = NUM_PEERS - 1; p >= 0; p--) begin
            if (mask[p]) pick = PEER_W'(p);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && i_command == CMD_TICK && r_enable) n_state = S_EXP;
            S_EXP:  if (!(r_wbase <= r_now && r_nexp < CNT_W'(WHEEL_SLOTS))) n_state = S_NEW;
            S_NEW:  n_state = any ? S_DISP : S_BKT;
            S_BKT: begin
                if (r_pos >= r_nexp) n_state = S_DLY;
                else if (any) n_state = S_DISP;
            end
            S_DISP: n_state = r_phase_bkt ? S_BKT : S_NEW;
            S_DLY:  if (!(inext < {1'b0, r_interval}) || any) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_command == CMD_RECORD && int'(i_peer_id) < NUM_PEERS) begin
            mem_tx[i_peer_id] <= i_now_seconds;
        end
        if ((r_state == S_NEW || (r_state == S_BKT && r_pos < r_nexp)) && any) begin
            r_rdata <= mem_tx[pick];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= KI_W'(20);
            r_enable   <= 1'b1;
            r_base     <= '0;
            r_cursor   <= '0;
            r_ovalid   <= 1'b0;
            for (int p = 0; p < NUM_PEERS; p++) r_status[p] <= ST_FREE;
        end else begin
            r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                    default:      ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now   <= i_now_seconds;
                        r_wbase <= r_base;
                        r_nexp  <= '0;
                        r_pos   <= '0;
                        r_i     <= '0;
                        r_coll  <= '0;
                        r_oldcur    <= r_cursor[SLOT_W-1:0];
                        r_phase_bkt <= 1'b0;
                        if (int'(i_peer_id) < NUM_PEERS) begin
                            case (i_command)
                                CMD_ADD: begin
                                    if (r_status[i_peer_id] != ST_NEW &&
                                        r_status[i_peer_id] != ST_WHEEL)
                                        r_status[i_peer_id] <= ST_NEW;
                                end
                                CMD_REMOVE: r_status[i_peer_id] <= ST_FREE;
                                default: ;
                            endcase
                        end
                    end
                end
                S_EXP: begin
                    if (r_wbase <= r_now && r_nexp < CNT_W'(WHEEL_SLOTS)) begin
                        r_wbase <= r_wbase + 1'b1;
                        r_nexp  <= r_nexp + 1'b1;
                    end else begin
                        r_base   <= r_now;
                        r_cursor <= r_cursor + CUR_W'(r_nexp);
                    end
                end
                S_NEW: begin
                    r_pid <= pick;
                    if (!any) r_phase_bkt <= 1'b1;
                end
                S_BKT: begin
                    if (r_pos < r_nexp) begin
                        if (any) r_pid <= pick;
                        else r_pos <= r_pos + 1'b1;
                    end
                end
                S_DISP: begin
                    r_bucket[r_pid] <= dres.bucket;
                    r_status[r_pid] <= ST_WHEEL;
                    r_coll[r_pid]   <= 1'b1;
                    if (dres.ping) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_PING;
                        r_opid   <= r_pid;
                        r_odelay <= '0;
                        r_olast  <= 1'b0;
                    end
                end
                S_DLY: begin
                    if (!(inext < {1'b0, r_interval}) || any) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_DELAY;
                        r_opid   <= '0;
                        r_odelay <= (r_i == '0) ? KI_W'(1) : r_i;
                        r_olast  <= 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_kind          = r_okind;
    assign o_peer_id_res   = r_opid;
    assign o_delay_seconds = r_odelay;
    assign o_last          = r_olast;
endmodule
`default_nettype wire

// ----- hw/rtl/ktw_dispatch.sv -----
// Shared dispatch unit: ping decision and new bucket of one peer.
`default_nettype none
module ktw_dispatch
    import ktw_pkg::*;
(
    input  wire logic [TIME_W-1:0] i_last_tx,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic [KI_W-1:0]   i_interval,
    input  wire logic [SLOT_W-1:0] i_cursor,
    output t_disp                  o_res
);
    logic [TIME_W:0]   at;
    logic [TIME_W:0]   lim;
    logic [TIME_W:0]   diff;
    logic [SLOT_W-1:0] slot;
    logic              ping;

    always_comb begin
        at   = {1'b0, i_last_tx} + (TIME_W+1)'(i_interval);
        lim  = {1'b0, i_now} + (TIME_W+1)'(i_interval);
        diff = at - {1'b0, i_now};
        ping = (at <= {1'b0, i_now}) || (at > lim);
        slot = ping ? SLOT_W'(i_interval) : diff[SLOT_W-1:0];
        o_res.ping   = ping;
        o_res.bucket = slot + i_cursor;
    end
endmodule
`default_nettype wire
